@@ hdl/swkc_pkg.sv @@
package swkc_pkg;

   localparam int DEFAULT_MAX_WINDOW = 1024;
   localparam int DEFAULT_KIND_COUNT = 5;

   localparam int SYMBOL_W    = 3;
   localparam int CFG_DATA_W  = 11;
   localparam int CFG_INDEX_W = 3;
   localparam int KIND_W      = 3;
   localparam int MINIMUM_W   = 11;
   localparam int TOTAL_W     = 32;

   // Register index map of the configuration port.
   localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH  = 3'd0;
   localparam logic [CFG_INDEX_W-1:0] REG_FIRST_KIND     = 3'd1;
   localparam logic [CFG_INDEX_W-1:0] REG_FIRST_MINIMUM  = 3'd2;
   localparam logic [CFG_INDEX_W-1:0] REG_SECOND_KIND    = 3'd3;
   localparam logic [CFG_INDEX_W-1:0] REG_SECOND_MINIMUM = 3'd4;

   localparam logic [KIND_W-1:0] FIRST_KIND_RESET  = 3'd0;
   localparam logic [KIND_W-1:0] SECOND_KIND_RESET = 3'd1;

endpackage

@@ hdl/swkc_cell.sv @@
module swkc_cell
   import swkc_pkg::*;
(
   input  logic                clock,
   input  logic                advance,
   input  logic                load,
   input  logic [SYMBOL_W-1:0] load_sym,
   input  logic [SYMBOL_W-1:0] shift_sym,
   output logic [SYMBOL_W-1:0] sym_out
);

   logic [SYMBOL_W-1:0] sym_ff;
   logic [SYMBOL_W-1:0] sym_in;

   // The cell at the insert point takes the new symbol, all others take their neighbor's.
   assign sym_in  = load ? load_sym : shift_sym;
   assign sym_out = sym_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sym_ff <= sym_in;
      end
   end

endmodule

@@ hdl/swkc_chain.sv @@
module swkc_chain
   import swkc_pkg::*;
#(
   parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
)
(
   input  logic                          clock,
   input  logic                          advance,
   input  logic [$clog2(MAX_WINDOW)-1:0] insert_pos,
   input  logic [SYMBOL_W-1:0]           new_sym,
   output logic [SYMBOL_W-1:0]           tail_sym
);

   localparam int IW = $clog2(MAX_WINDOW);

   logic [SYMBOL_W-1:0] cell_sym [MAX_WINDOW];

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic [SYMBOL_W-1:0] from_prev;

      if (i == 0) begin : g_head
         assign from_prev = new_sym;
      end else begin : g_body
         assign from_prev = cell_sym[i-1];
      end

      swkc_cell u_cell (
         .clock     (clock),
         .advance   (advance),
         .load      (insert_pos == IW'(i)),
         .load_sym  (new_sym),
         .shift_sym (from_prev),
         .sym_out   (cell_sym[i])
      );
   end

   // The symbol leaving the window always sits in the last cell.
   assign tail_sym = cell_sym[MAX_WINDOW-1];

endmodule

@@ hdl/sliding_window_kind_count_match.sv @@
// Sliding-window kind counter with two count thresholds.
//
// Input channel (req_): one symbol per transfer, counted if of kind 0..KIND_COUNT-1, with
// req_final_item marking the last symbol of a sequence. Result channel (rsp_):
// one result per input transfer, in order: window_hit for the window ending at
// that symbol, the saturating hit_total of the sequence so far, and
// sequence_end copied from final_item. After the final symbol all sequence
// state clears; writing window_length does the same.
//
// A result is registered at the edge that takes its symbol. Throughput is one
// symbol per cycle while the receiver does not stall; the count update and
// threshold test are combinational. The window is a chain of MAX_WINDOW symbol
// cells that shift on every transfer; the new symbol enters at cell
// MAX_WINDOW-length so the departing one always appears at the last cell.
//
// When the receiver stalls, the held result stays in the output register and
// req_stall rises, so at most one result waits. Reset clears counts, fill
// level, total and the output valid, and restores the register defaults; the
// cell chain needs no clearing, since only cells written in the current
// sequence are ever read.
module sliding_window_kind_count_match
   import swkc_pkg::*;
#(
   parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
   parameter int KIND_COUNT = DEFAULT_KIND_COUNT
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SYMBOL_W-1:0]    req_symbol,
   input  logic                   req_final_item,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_window_hit,
   output logic [TOTAL_W-1:0]     rsp_hit_total,
   output logic                   rsp_sequence_end,

   input  logic                   csr_write_enable,
   input  logic [CFG_INDEX_W-1:0] csr_index,
   input  logic [CFG_DATA_W-1:0]  csr_write_data
);

   localparam int IW = $clog2(MAX_WINDOW);      // cell index width
   localparam int LW = $clog2(MAX_WINDOW + 1);  // window length / count width

   // Configuration
   logic [LW-1:0]        active_len_ff, active_len_in;
   logic [IW-1:0]        insert_pos_ff, insert_pos_in;
   logic [KIND_W-1:0]    first_kind_ff, second_kind_ff;
   logic [MINIMUM_W-1:0] first_min_ff, second_min_ff;
   logic                 len_write;

   // Sequence state
   logic [LW-1:0]        counts_ff [KIND_COUNT];
   logic [LW-1:0]        counts_in [KIND_COUNT];
   logic [LW-1:0]        counts_upd [KIND_COUNT];
   logic [LW-1:0]        fill_ff, fill_in, fill_upd;
   logic [TOTAL_W-1:0]   total_ff, total_in, total_upd;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff;
   logic [TOTAL_W-1:0]   rsp_total_ff;
   logic                 rsp_end_ff;

   logic                 accept;
   logic                 full_before;
   logic                 full_after;
   logic [SYMBOL_W-1:0]  old_sym;
   logic [LW-1:0]        first_count, second_count;
   logic                 hit;

   // Take a new symbol whenever the output register is empty or drains this cycle.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Clamp the window length: zero acts as one, anything above MAX_WINDOW as MAX_WINDOW.
   assign len_write = csr_write_enable && (csr_index == REG_WINDOW_LENGTH);

   always_comb begin
      if (csr_write_data == '0) begin
         active_len_in = LW'(1);
      end else if (32'(csr_write_data) > 32'(MAX_WINDOW)) begin
         active_len_in = LW'(MAX_WINDOW);
      end else begin
         active_len_in = LW'(csr_write_data);
      end
      insert_pos_in = IW'(32'(MAX_WINDOW) - 32'(active_len_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_len_ff  <= LW'(1);
         insert_pos_ff  <= IW'(MAX_WINDOW - 1);
         first_kind_ff  <= FIRST_KIND_RESET;
         first_min_ff   <= '0;
         second_kind_ff <= SECOND_KIND_RESET;
         second_min_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_WINDOW_LENGTH: begin
               active_len_ff <= active_len_in;
               insert_pos_ff <= insert_pos_in;
            end
            REG_FIRST_KIND:     first_kind_ff  <= csr_write_data[KIND_W-1:0];
            REG_FIRST_MINIMUM:  first_min_ff   <= csr_write_data[MINIMUM_W-1:0];
            REG_SECOND_KIND:    second_kind_ff <= csr_write_data[KIND_W-1:0];
            REG_SECOND_MINIMUM: second_min_ff  <= csr_write_data[MINIMUM_W-1:0];
            default: ;  // drop writes beyond the register map
         endcase
      end
   end

   // Window cells: shift once per transfer.
   swkc_chain #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_chain (
      .clock      (clock),
      .advance    (accept),
      .insert_pos (insert_pos_ff),
      .new_sym    (req_symbol),
      .tail_sym   (old_sym)
   );

   // Per-kind counts: the incoming symbol adds one, the departing one (once the
   // window is full) removes one. Kinds out of range count nowhere.
   assign full_before = (fill_ff >= active_len_ff);
   assign fill_upd    = full_before ? fill_ff : fill_ff + LW'(1);
   assign full_after  = (fill_upd >= active_len_ff);

   always_comb begin
      logic inc;
      logic dec;
      for (int k = 0; k < KIND_COUNT; k++) begin
         inc = (32'(req_symbol) == k);
         dec = full_before && (32'(old_sym) == k) && (counts_ff[k] != '0);
         if (inc && !dec) begin
            counts_upd[k] = counts_ff[k] + LW'(1);
         end else if (dec && !inc) begin
            counts_upd[k] = counts_ff[k] - LW'(1);
         end else begin
            counts_upd[k] = counts_ff[k];
         end
      end
   end

   // Select the two tested counts; a tested kind out of range reads as zero.
   always_comb begin
      first_count  = '0;
      second_count = '0;
      for (int k = 0; k < KIND_COUNT; k++) begin
         if (32'(first_kind_ff) == k) begin
            first_count = counts_upd[k];
         end
         if (32'(second_kind_ff) == k) begin
            second_count = counts_upd[k];
         end
      end
   end

   assign hit = full_after
              && (32'(first_count) >= 32'(first_min_ff))
              && (32'(second_count) >= 32'(second_min_ff));

   // Saturate the running total.
   assign total_upd = (hit && (total_ff != '1)) ? total_ff + TOTAL_W'(1) : total_ff;

   // The final symbol clears the sequence after its result is formed.
   always_comb begin
      for (int k = 0; k < KIND_COUNT; k++) begin
         counts_in[k] = req_final_item ? '0 : counts_upd[k];
      end
      fill_in  = req_final_item ? '0 : fill_upd;
      total_in = req_final_item ? '0 : total_upd;
   end

   always_ff @(posedge clock) begin
      if (reset || len_write) begin
         for (int k = 0; k < KIND_COUNT; k++) begin
            counts_ff[k] <= '0;
         end
         fill_ff  <= '0;
         total_ff <= '0;
      end else if (accept) begin
         for (int k = 0; k < KIND_COUNT; k++) begin
            counts_ff[k] <= counts_in[k];
         end
         fill_ff  <= fill_in;
         total_ff <= total_in;
      end
   end

   // Output register: load on transfer in, hold while stalled.
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff   <= hit;
         rsp_total_ff <= total_upd;
         rsp_end_ff   <= req_final_item;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_hit   = rsp_hit_ff;
   assign rsp_hit_total    = rsp_total_ff;
   assign rsp_sequence_end = rsp_end_ff;

endmodule

@@ tb/tb_sliding_window_kind_count_match.sv @@
module tb_sliding_window_kind_count_match;
   import swkc_pkg::*;

   // Cycles with no transfer and no register write before the run is abandoned.
   // The slowest correct run stalls the receiver 85% of the time, so this is far
   // beyond any credible stretch of back-to-back stalls.
   localparam int WATCHDOG_LIMIT = 2000;
   // Idle time that lets the block settle before a register write.
   localparam int SETTLE_CYCLES  = 3;
   localparam int LAST_INDEX     = (1 << CFG_INDEX_W) - 1;

   typedef enum {SENDER_LIGHT, SENDER_HEAVY, NO_GAPS} idle_pattern_type;

   typedef struct {
      logic               hit;
      logic [TOTAL_W-1:0] total;
      logic               last;
   } window_verdict_type;

   // Tracks the window contents and per-kind tallies, and keeps the queue of
   // verdicts still owed by the block.
   class window_match_board_type;
      logic [CFG_DATA_W-1:0] length_reg;
      logic [KIND_W-1:0]     kind_a, kind_b;
      logic [MINIMUM_W-1:0]  min_a, min_b;
      logic [SYMBOL_W-1:0]   window_syms[$];
      logic [MINIMUM_W-1:0]  tally[DEFAULT_KIND_COUNT];
      logic [TOTAL_W-1:0]    running_hits;
      window_verdict_type    awaited[$];
      int                    noted, checked, mismatches;

      function new();
         length_reg = 1;
         kind_a     = FIRST_KIND_RESET;
         min_a      = 0;
         kind_b     = SECOND_KIND_RESET;
         min_b      = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         window_syms.delete();
         foreach (tally[k]) tally[k] = 0;
         running_hits = 0;
      endfunction

      function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
         case (idx)
            REG_WINDOW_LENGTH: begin
               length_reg = data;
               clear_sequence();
            end
            REG_FIRST_KIND:     kind_a = data[KIND_W-1:0];
            REG_FIRST_MINIMUM:  min_a  = data;
            REG_SECOND_KIND:    kind_b = data[KIND_W-1:0];
            REG_SECOND_MINIMUM: min_b  = data;
            default: ;
         endcase
      endfunction

      function logic [MINIMUM_W-1:0] tally_of(logic [KIND_W-1:0] k);
         return (k < DEFAULT_KIND_COUNT) ? tally[k] : '0;
      endfunction

      function void note_symbol(logic [SYMBOL_W-1:0] sym, logic last);
         int              len;
         logic [SYMBOL_W-1:0] gone;
         window_verdict_type v;
         len = (length_reg == 0) ? 1 :
               (length_reg > DEFAULT_MAX_WINDOW) ? DEFAULT_MAX_WINDOW : int'(length_reg);
         if (window_syms.size() >= len) begin
            gone = window_syms.pop_front();
            if (gone < DEFAULT_KIND_COUNT && tally[gone] > 0) tally[gone]--;
         end
         window_syms.push_back(sym);
         if (sym < DEFAULT_KIND_COUNT) tally[sym]++;
         v.hit = (window_syms.size() >= len) && (tally_of(kind_a) >= min_a)
                 && (tally_of(kind_b) >= min_b);
         if (v.hit && running_hits != '1) running_hits++;
         v.total = running_hits;
         v.last  = last;
         awaited.push_back(v);
         noted++;
         if (last) clear_sequence();
      endfunction

      function void check_result(logic hit, logic [TOTAL_W-1:0] total, logic last);
         window_verdict_type want;
         if (awaited.size() == 0) begin
            $display("%0t: result with none expected: hit=%0b total=%0d end=%0b",
                     $time, hit, total, last);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (hit !== want.hit || total !== want.total || last !== want.last) begin
            $display("%0t: mismatch: expected hit=%0b total=%0d end=%0b,",
                     $time, want.hit, want.total, want.last);
            $display("%0t:           got hit=%0b total=%0d end=%0b",
                     $time, hit, total, last);
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [SYMBOL_W-1:0]    req_symbol       = '0;
   logic                   req_final_item   = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic                   rsp_window_hit;
   logic [TOTAL_W-1:0]     rsp_hit_total;
   logic                   rsp_sequence_end;
   logic                   csr_write_enable = 1'b0;
   logic [CFG_INDEX_W-1:0] csr_index        = '0;
   logic [CFG_DATA_W-1:0]  csr_write_data   = '0;

   int sender_gap_pct = 0;
   int stall_pct      = 0;
   int idle_cycles    = 0;
   int settings_run   = 0;

   window_match_board_type board = new();

   sliding_window_kind_count_match DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_symbol       (req_symbol),
      .req_final_item   (req_final_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_hit   (rsp_window_hit),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_sequence_end (rsp_sequence_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: decide the stall for the next edge at each falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Check every result transfer against the oldest owed verdict.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_window_hit, rsp_hit_total, rsp_sequence_end);
   end

   // Watchdog: abandon the run after a long stretch with nothing moving.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         idle_cycles <= 0;
      else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, WATCHDOG_LIMIT, board.awaited.size());
         $display("FAIL sliding_window_kind_count_match");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic select_pattern(input idle_pattern_type p);
      case (p)
         SENDER_LIGHT: begin sender_gap_pct = 18; stall_pct = 85; end
         SENDER_HEAVY: begin sender_gap_pct = 85; stall_pct = 18; end
         default:      begin sender_gap_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   // Offer one symbol, hold it through any stall, and note it once transferred.
   task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_symbol     <= sym;
      req_final_item <= last;
      do @(posedge clock); while (req_stall);
      board.note_symbol(sym, last);
   endtask

   // Drop valid, wait for every owed result, then let the block settle.
   task automatic quiesce();
      @(negedge clock) req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CFG_INDEX_W-1:0] idx, input int unsigned data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data[CFG_DATA_W-1:0];
      @(posedge clock);
      board.write_register(idx, data[CFG_DATA_W-1:0]);
      @(negedge clock) csr_write_enable <= 1'b0;
   endtask

   // Write all five registers while idle. Kind writes carry random upper bits,
   // which the block must drop.
   task automatic configure(input int unsigned span, ka, ma, kb, mb);
      quiesce();
      write_csr(REG_FIRST_KIND,     {21'd0, 8'($urandom_range(255)), ka[KIND_W-1:0]});
      write_csr(REG_FIRST_MINIMUM,  ma);
      write_csr(REG_SECOND_KIND,    {21'd0, 8'($urandom_range(255)), kb[KIND_W-1:0]});
      write_csr(REG_SECOND_MINIMUM, mb);
      write_csr(REG_WINDOW_LENGTH,  span);
      settings_run++;
   endtask

   // Stream random sequences under one setting. Symbols lean toward the two
   // tested kinds so thresholds are actually met; the rest is any 3-bit value.
   task automatic run_phase(input int unsigned span, ka, ma, kb, mb,
                            input int items, input int longest);
      int                  left;
      int                  pick;
      logic [SYMBOL_W-1:0] sym;
      configure(span, ka, ma, kb, mb);
      left = $urandom_range(longest, 1);
      for (int n = 0; n < items; n++) begin
         // Hold the sender mid-phase until the block has delivered everything.
         if (n == items / 2) quiesce();
         pick = $urandom_range(9);
         sym  = (pick < 3) ? ka[SYMBOL_W-1:0] :
                (pick < 6) ? kb[SYMBOL_W-1:0] : SYMBOL_W'($urandom_range(7));
         send_symbol(sym, left == 1 || n == items - 1);
         left = (left == 1) ? $urandom_range(longest, 1) : left - 1;
      end
   endtask

   function automatic int unsigned pick_kind();
      return ($urandom_range(9) < 8) ? $urandom_range(DEFAULT_KIND_COUNT - 1)
                                     : $urandom_range(7, DEFAULT_KIND_COUNT);
   endfunction

   task automatic run_random_phase(input int items);
      int unsigned span;
      span = $urandom_range(16, 1);
      run_phase(span, pick_kind(), $urandom_range(span), pick_kind(), $urandom_range(span),
                items, 3 * span + 5);
   endtask

   initial begin
      select_pattern(SENDER_LIGHT);
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Reset defaults: window of one, both minimums zero, so every symbol hits.
      // Sweep every symbol value, including those beyond the kinds.
      for (int s = 0; s < 8; s++) send_symbol(SYMBOL_W'(s), s == 7);

      // Window of three: two of kind 2 and one of kind 4 needed. Fill, hit twice,
      // then let an uncounted symbol push kind 2 below its minimum.
      configure(3, 2, 2, 4, 1);
      send_symbol(3'd2, 1'b0);
      send_symbol(3'd2, 1'b0);
      send_symbol(3'd4, 1'b0);
      send_symbol(3'd2, 1'b0);
      send_symbol(3'd7, 1'b0);
      send_symbol(3'd2, 1'b0);
      send_symbol(3'd4, 1'b1);
      // Sequence shorter than the window: never full, total stays zero.
      send_symbol(3'd2, 1'b0);
      send_symbol(3'd4, 1'b1);

      // Tested kinds beyond the kind range read as zero; a minimum of one fails.
      // Unmapped register indexes must be ignored.
      configure(3, 5, 0, 7, 1);
      for (int idx = REG_SECOND_MINIMUM + 1; idx <= LAST_INDEX; idx++)
         write_csr(CFG_INDEX_W'(idx), $urandom_range(2047));
      send_symbol(3'd6, 1'b0);
      send_symbol(3'd5, 1'b0);
      send_symbol(3'd3, 1'b1);

      // Window length zero acts as one; zero minimums on out-of-range kinds pass.
      configure(0, 5, 0, 7, 0);
      send_symbol(3'd4, 1'b0);
      send_symbol(3'd1, 1'b1);

      // Random part, sender light and receiver heavy.
      run_phase(4, 0, 1, 3, 2, 40, 25);
      run_phase(1, 4, 1, 4, 1, 20, 10);
      run_phase(1024, 0, 0, 1, 0, 20, 15);
      run_random_phase(30);

      // Swap: sender heavy, receiver light.
      select_pattern(SENDER_HEAVY);
      run_phase(7, 5, 0, 6, 0, 30, 30);
      run_phase(0, 2, 0, 3, 1, 20, 12);
      run_random_phase(30);
      run_random_phase(30);

      // No idling. The length register at all ones clamps to the maximum window,
      // which these sequences never fill; then unreachable minimums.
      select_pattern(NO_GAPS);
      run_phase(2047, 1, 0, 2, 0, 60, 60);
      run_phase(2, 3, 2047, 0, 2047, 20, 6);
      run_random_phase(40);
      run_random_phase(40);

      quiesce();
      $display("Covered %0d symbols over %0d register settings (windows 0 to 2047, kinds 0 to 7),",
               board.noted, settings_run);
      $display("under three idle patterns; %0d results checked, %0d mismatches.",
               board.checked, board.mismatches);
      if (board.mismatches == 0 && board.awaited.size() == 0)
         $display("PASS sliding_window_kind_count_match");
      else
         $display("FAIL sliding_window_kind_count_match");
      $finish;
   end

endmodule
